>>> hdl/assert_macros.svh
// assertion macros shared by the latency block
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define NLJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define NLJ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/nlj_pkg.sv
// shared types, constants and helpers for the nand latency block
// no dependencies
`default_nettype none

package nlj_pkg;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_PROG  = 2'd1,
    FUNC_ERASE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // page kinds
  localparam logic [1:0] KIND_LSB = 2'd0;
  localparam logic [1:0] KIND_CSB = 2'd1;
  localparam logic [1:0] KIND_MSB = 2'd2;

  // register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LSB = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_CSB = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READ_MSB = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROG_LSB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROG_CSB = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROG_MSB = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER   = 3'd7;

  localparam int unsigned LAT_W  = 32;
  localparam int unsigned OUT_W  = 33;
  localparam int unsigned BP_W   = 14;
  localparam int unsigned PAGE_W = 24;

  localparam logic [BP_W-1:0] MAX_JITTER_BP = 14'd10000;

  // generator
  localparam logic [63:0] JITTER_SEED = 64'd0;
  localparam logic [63:0] LCG_MUL     = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] LCG_INC     = 64'h1405_7B7E_F767_814F;

  // remainder unit
  localparam int unsigned DQ_W   = 46;
  localparam int unsigned REM_W  = 16;
  localparam int unsigned DVSR_W = 15;
  localparam int unsigned CNT_W  = 5;
  localparam logic [DVSR_W-1:0] BP_SCALE  = 15'd10000;
  localparam logic [CNT_W-1:0]  RND_STEPS = 5'd16;
  localparam logic [CNT_W-1:0]  SCL_STEPS = 5'd23;

  // multiplier operand select
  typedef enum logic [1:0] {
    MUL_LO_ML    = 2'd0,
    MUL_HI_ML    = 2'd1,
    MUL_LO_MH    = 2'd2,
    MUL_BASE_MAG = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     acc_init;
    logic     acc_add;
    logic     lcg_write;
    logic     div_load_rnd;
    logic     div_load_scl;
    logic     div_step;
    logic     delta_load;
    logic     out_load;
  } nlj_cmd_t;

  typedef struct packed {
    logic skip;
    logic div_last;
  } nlj_sts_t;

  // page index mod 3: nibbles sum since 16 is 1 mod 3, then base-4 digits
  function automatic logic [1:0] page_kind(input logic [PAGE_W-1:0] page);
    logic [6:0] s1;
    logic [3:0] s2;
    logic [1:0] k;
    s1 = '0;
    for (int i = 0; i < PAGE_W / 4; i++) begin
      s1 = s1 + 7'(page[4*i +: 4]);
    end
    s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]) + 4'(s1[6]);
    unique case (s2)
      4'd0, 4'd3, 4'd6, 4'd9:  k = KIND_LSB;
      4'd1, 4'd4, 4'd7, 4'd10: k = KIND_CSB;
      4'd2, 4'd5, 4'd8:        k = KIND_MSB;
      default:                 k = KIND_LSB;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> hdl/nlj_ctrl.sv
// sequencer for the nand latency block: one item at a time
// depends on nlj_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module nlj_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire nlj_pkg::nlj_sts_t sts,
  output nlj_pkg::nlj_cmd_t     cmd
);

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0_0000_0000_0001,
    ST_CHECK   = 13'b0_0000_0000_0010,
    ST_LCG0    = 13'b0_0000_0000_0100,
    ST_LCG1    = 13'b0_0000_0000_1000,
    ST_LCG2    = 13'b0_0000_0001_0000,
    ST_LCG3    = 13'b0_0000_0010_0000,
    ST_DIVR_LD = 13'b0_0000_0100_0000,
    ST_DIVR    = 13'b0_0000_1000_0000,
    ST_DELTA   = 13'b0_0001_0000_0000,
    ST_SMUL    = 13'b0_0010_0000_0000,
    ST_DIVS_LD = 13'b0_0100_0000_0000,
    ST_DIVS    = 13'b0_1000_0000_0000,
    ST_FINISH  = 13'b1_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = nlj_pkg::MUL_LO_ML;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.skip ? ST_FINISH : ST_LCG0;
      end
      ST_LCG0: begin
        cmd.mul_sel = nlj_pkg::MUL_LO_ML;
        state_nxt   = ST_LCG1;
      end
      ST_LCG1: begin
        cmd.mul_sel  = nlj_pkg::MUL_HI_ML;
        cmd.acc_init = 1'b1;
        state_nxt    = ST_LCG2;
      end
      ST_LCG2: begin
        cmd.mul_sel = nlj_pkg::MUL_LO_MH;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_LCG3;
      end
      ST_LCG3: begin
        cmd.lcg_write = 1'b1;
        state_nxt     = ST_DIVR_LD;
      end
      ST_DIVR_LD: begin
        cmd.div_load_rnd = 1'b1;
        state_nxt        = ST_DIVR;
      end
      ST_DIVR: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd.delta_load = 1'b1;
        state_nxt      = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.mul_sel = nlj_pkg::MUL_BASE_MAG;
        state_nxt   = ST_DIVS_LD;
      end
      ST_DIVS_LD: begin
        cmd.div_load_scl = 1'b1;
        state_nxt        = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `NLJ_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "second item taken while busy")
  `NLJ_ASSERT(a_no_overwrite, (out_valid_r && !out_ready) |-> !cmd.out_load,
              "pending result overwritten")
  `NLJ_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

`default_nettype wire

>>> hdl/nlj_dp.sv
// datapath for the nand latency block: registers, generator, multiplier,
// two-bit-per-cycle remainder unit and result register; depends on nlj_pkg
`default_nettype none

`include "assert_macros.svh"

module nlj_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [nlj_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nlj_pkg::LAT_W-1:0]         cfg_data,
  input  wire logic [1:0]                        in_func,
  input  wire logic [nlj_pkg::PAGE_W-1:0]        in_page_index,
  output logic [nlj_pkg::OUT_W-1:0]              out_latency_ns,
  input  wire nlj_pkg::nlj_cmd_t                 cmd,
  output nlj_pkg::nlj_sts_t                      sts
);

  logic [nlj_pkg::LAT_W-1:0] read_lsb_r, read_csb_r, read_msb_r;
  logic [nlj_pkg::LAT_W-1:0] prog_lsb_r, prog_csb_r, prog_msb_r;
  logic [nlj_pkg::LAT_W-1:0] erase_r;
  logic [nlj_pkg::BP_W-1:0]  jbp_r;
  logic [63:0]               lcg_r, lcg_nxt;

  logic [nlj_pkg::LAT_W-1:0] base_r, base_nxt;
  logic [nlj_pkg::BP_W-1:0]  bp_r, bp_nxt;
  logic [1:0]                kind;
  logic [63:0]               p_r, p_nxt;
  logic [31:0]               mul_a, mul_b;
  logic [63:0]               acc_r;

  logic [nlj_pkg::DQ_W-1:0]   dq_r, dq_nxt;
  logic [nlj_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [nlj_pkg::DVSR_W-1:0] dvsr_r;
  logic [nlj_pkg::CNT_W-1:0]  cnt_r;
  logic [nlj_pkg::REM_W:0]    trial;
  logic                       ge;

  logic [nlj_pkg::BP_W-1:0]  mag_r;
  logic                      neg_r;
  logic [nlj_pkg::OUT_W-1:0] quo, base_x, half_x, up_x, dn_x, res;
  logic [nlj_pkg::OUT_W-1:0] out_lat_r;

  // base latency pick
  always_comb begin
    kind = nlj_pkg::page_kind(in_page_index);
    unique case (in_func)
      nlj_pkg::FUNC_READ: begin
        unique case (kind)
          nlj_pkg::KIND_LSB: base_nxt = read_lsb_r;
          nlj_pkg::KIND_CSB: base_nxt = read_csb_r;
          default:           base_nxt = read_msb_r;
        endcase
      end
      nlj_pkg::FUNC_PROG: begin
        unique case (kind)
          nlj_pkg::KIND_LSB: base_nxt = prog_lsb_r;
          nlj_pkg::KIND_CSB: base_nxt = prog_csb_r;
          default:           base_nxt = prog_msb_r;
        endcase
      end
      nlj_pkg::FUNC_ERASE: base_nxt = erase_r;
      default:             base_nxt = '0;
    endcase
    bp_nxt = (jbp_r > nlj_pkg::MAX_JITTER_BP) ? nlj_pkg::MAX_JITTER_BP : jbp_r;
  end

  assign sts.skip     = (base_r == '0) || (bp_r == '0);
  assign sts.div_last = (cnt_r == '0);

  // shared 32x32 multiplier, registered product
  always_comb begin
    unique case (cmd.mul_sel)
      nlj_pkg::MUL_LO_ML: begin
        mul_a = lcg_r[31:0];
        mul_b = nlj_pkg::LCG_MUL[31:0];
      end
      nlj_pkg::MUL_HI_ML: begin
        mul_a = lcg_r[63:32];
        mul_b = nlj_pkg::LCG_MUL[31:0];
      end
      nlj_pkg::MUL_LO_MH: begin
        mul_a = lcg_r[31:0];
        mul_b = nlj_pkg::LCG_MUL[63:32];
      end
      default: begin
        mul_a = base_r;
        mul_b = 32'(mag_r);
      end
    endcase
    p_nxt   = 64'(mul_a) * 64'(mul_b);
    lcg_nxt = acc_r + {p_r[31:0], 32'd0};
  end

  // two restoring remainder steps a cycle
  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    trial   = '0;
    ge      = 1'b0;
    for (int k = 0; k < 2; k++) begin
      trial   = {rem_nxt, dq_nxt[nlj_pkg::DQ_W-1]};
      ge      = (trial >= (nlj_pkg::REM_W+1)'(dvsr_r));
      rem_nxt = ge ? nlj_pkg::REM_W'(trial - (nlj_pkg::REM_W+1)'(dvsr_r))
                   : trial[nlj_pkg::REM_W-1:0];
      dq_nxt  = {dq_nxt[nlj_pkg::DQ_W-2:0], ge};
    end
  end

  // final latency: signed scale applied as magnitude, then half-base floor
  always_comb begin
    quo    = dq_r[nlj_pkg::OUT_W-1:0];
    base_x = nlj_pkg::OUT_W'(base_r);
    half_x = nlj_pkg::OUT_W'(base_r[nlj_pkg::LAT_W-1:1]);
    up_x   = base_x + quo;
    dn_x   = base_x - quo;
    priority if (sts.skip) begin
      res = base_x;
    end else if (!neg_r) begin
      res = up_x;
    end else if (dn_x < half_x) begin
      res = half_x;
    end else begin
      res = dn_x;
    end
  end

  assign out_latency_ns = out_lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_lsb_r <= '0;
      read_csb_r <= '0;
      read_msb_r <= '0;
      prog_lsb_r <= '0;
      prog_csb_r <= '0;
      prog_msb_r <= '0;
      erase_r    <= '0;
      jbp_r      <= '0;
      lcg_r      <= nlj_pkg::JITTER_SEED;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          nlj_pkg::REG_READ_LSB: read_lsb_r <= cfg_data;
          nlj_pkg::REG_READ_CSB: read_csb_r <= cfg_data;
          nlj_pkg::REG_READ_MSB: read_msb_r <= cfg_data;
          nlj_pkg::REG_PROG_LSB: prog_lsb_r <= cfg_data;
          nlj_pkg::REG_PROG_CSB: prog_csb_r <= cfg_data;
          nlj_pkg::REG_PROG_MSB: prog_msb_r <= cfg_data;
          nlj_pkg::REG_ERASE:    erase_r    <= cfg_data;
          default:               jbp_r      <= cfg_data[nlj_pkg::BP_W-1:0];
        endcase
      end
      if (cmd.lcg_write) begin
        lcg_r <= lcg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (cmd.load) begin
      base_r <= base_nxt;
      bp_r   <= bp_nxt;
    end
    if (cmd.acc_init) begin
      acc_r <= p_r + nlj_pkg::LCG_INC;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {p_r[31:0], 32'd0};
    end
    if (cmd.div_load_rnd) begin
      dq_r   <= {lcg_r[63:32], (nlj_pkg::DQ_W-32)'(0)};
      rem_r  <= '0;
      dvsr_r <= {bp_r, 1'b1};
      cnt_r  <= nlj_pkg::RND_STEPS - 1'b1;
    end else if (cmd.div_load_scl) begin
      dq_r   <= p_r[nlj_pkg::DQ_W-1:0];
      rem_r  <= '0;
      dvsr_r <= nlj_pkg::BP_SCALE;
      cnt_r  <= nlj_pkg::SCL_STEPS - 1'b1;
    end else if (cmd.div_step) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.delta_load) begin
      neg_r <= (rem_r < nlj_pkg::REM_W'(bp_r));
      mag_r <= (rem_r < nlj_pkg::REM_W'(bp_r))
             ? nlj_pkg::BP_W'(nlj_pkg::REM_W'(bp_r) - rem_r)
             : nlj_pkg::BP_W'(rem_r - nlj_pkg::REM_W'(bp_r));
    end
    if (cmd.out_load) begin
      out_lat_r <= res;
    end
  end

  `NLJ_ASSERT(a_gen_when_jitter, cmd.lcg_write |-> !sts.skip,
              "generator advanced without active jitter")
  `NLJ_ASSERT(a_mag_range, $past(cmd.delta_load) |-> (mag_r <= nlj_pkg::MAX_JITTER_BP),
              "jitter offset beyond span")
  `NLJ_ASSERT(a_div_ends, (cmd.div_step && sts.div_last) |=> !cmd.div_step,
              "remainder unit stepped past its count")

endmodule

`default_nettype wire

>>> hdl/nand_latency_with_jitter.sv
// top level of the nand latency block: controller plus datapath
// depends on nlj_pkg, nlj_ctrl and nlj_dp
`default_nettype none

// Turns each read, program or erase item into one latency in ns. Read and
// program pick one of three base registers by page_index mod 3 (lsb, csb,
// msb); erase uses its own register; func 3 gives base 0. With jitter_bp
// nonzero (capped at 10000) and a nonzero base, a 64-bit lcg advances (three
// partial products through one 32x32 multiplier), its top half mod
// (2*bp+1) minus bp gives delta, and the result is base + trunc(base*delta
// /10000), floored at base/2. Items are worked one at a time: a jittered item
// passes check, generator, remainder, delta, scale multiply and scale divide
// states before the result register; an item with jitter off or base 0 goes
// from the check straight to it. The shared remainder unit retires two
// quotient bits a cycle, first for the random remainder, then for the divide
// by 10000. A finished result sits in an output register, so the next item is
// taken while it waits. Configuration is a plain write port (no read-back),
// index i for register i, and must only be written while the block is idle.
module nand_latency_with_jitter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [nlj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nlj_pkg::LAT_W-1:0]     cfg_data,
  // request items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_func,
  input  wire logic [nlj_pkg::PAGE_W-1:0]    in_page_index,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [nlj_pkg::OUT_W-1:0]          out_latency_ns
);

  // command and status between sequencer and datapath
  nlj_pkg::nlj_cmd_t cmd;
  nlj_pkg::nlj_sts_t sts;

  // sequencer: accepts an item, steps generator, remainder and scale phases
  nlj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: config registers, lcg, multiplier, divider, result register
  nlj_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_func        (in_func),
    .in_page_index  (in_page_index),
    .out_latency_ns (out_latency_ns),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

`default_nettype wire
